>>> src/report_ack_retry_scheduler_assert.svh
// Assertion macros used by the report scheduler controller.
`ifndef REPORT_ACK_RETRY_SCHEDULER_ASSERT_SVH
`define REPORT_ACK_RETRY_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RARS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("report scheduler assertion failed");

// Next-cycle implication, disabled during reset.
`define RARS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("report scheduler assertion failed");

`endif

>>> src/rars_pkg.sv
// Shared types and constants of the report scheduler.
package rars_pkg;

  localparam int RETRY_LIMIT_DEF  = 2;
  localparam int MIN_INTERVAL_DEF = 10;

  localparam logic [1:0] CFG_MODE     = 2'd0;
  localparam logic [1:0] CFG_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_FIRST_TS = 2'd2;

  typedef enum logic [1:0] {
    ALM_ZERO  = 2'd0,
    ALM_GRID  = 2'd1,
    ALM_NOREF = 2'd2
  } alarm_sel_t;

  typedef struct packed {
    logic       load_in;
    logic       div_start;
    logic       out_write;
    logic [3:0] action;
    logic [9:0] delay_ms;
    logic [1:0] retries;
    alarm_sel_t alarm_sel;
  } rars_cmd_t;

  typedef struct packed {
    logic       op;
    logic       conf_active;
    logic [1:0] ack_status;
    logic       fts_nonzero;
    logic       rem_le1;
    logic       div_done;
    logic       out_free;
  } rars_status_t;

endpackage

>>> src/rars_mod_unit.sv
// Serial 32-by-16 bit remainder unit, one quotient bit per cycle.
module rars_mod_unit import rars_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] rem
);

  logic        running;
  logic [4:0]  cnt;
  logic [31:0] dq;
  logic [15:0] dv;
  logic [16:0] r_sh;
  logic        ge;
  logic [16:0] r_sub;

  assign r_sh  = {rem, dq[31]};
  assign ge    = r_sh >= {1'b0, dv};
  assign r_sub = r_sh - {1'b0, dv};
  assign done  = !running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      cnt     <= '0;
    end else if (running) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      dv  <= divisor;
      rem <= '0;
    end else if (running) begin
      dq  <= {dq[30:0], 1'b0};
      rem <= ge ? r_sub[15:0] : r_sh[15:0];
    end
  end

endmodule

>>> src/rars_datapath.sv
// Datapath: configuration registers, input latch, remainder unit and output register.
module rars_datapath import rars_pkg::*; #(
  parameter int MIN_INTERVAL = MIN_INTERVAL_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         in_op,
  input  logic [34:0]  in_data,
  input  rars_cmd_t    cmd,
  output rars_status_t status,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [47:0]  m_tdata
);

  localparam logic [15:0] MIN_IVL       = MIN_INTERVAL[15:0];
  localparam logic [31:0] NO_REF_OFFSET = 32'd10;

  logic        operating_mode;
  logic [15:0] report_interval;
  logic [31:0] first_timestamp;
  logic        op_r;
  logic        conf_r;
  logic [31:0] time_r;
  logic [1:0]  ack_r;
  logic [15:0] eff_interval;
  logic [15:0] rem;
  logic        div_done;
  logic [31:0] alarm;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      operating_mode  <= 1'b0;
      report_interval <= 16'd10;
      first_timestamp <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:     operating_mode  <= cfg_data[0];
        CFG_INTERVAL: report_interval <= cfg_data[15:0];
        CFG_FIRST_TS: first_timestamp <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_op;
      conf_r <= in_data[0];
      time_r <= in_data[32:1];
      ack_r  <= in_data[34:33];
    end
  end

  assign eff_interval = (!operating_mode || report_interval < MIN_IVL) ? MIN_IVL
                                                                       : report_interval;

  rars_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (time_r - first_timestamp),
    .divisor  (eff_interval),
    .done     (div_done),
    .rem      (rem)
  );

  // The next grid point is now - remainder + interval, all modulo 2^32.
  always_comb begin
    case (cmd.alarm_sel)
      ALM_GRID:  alarm = time_r - {16'd0, rem} + {16'd0, eff_interval};
      ALM_NOREF: alarm = time_r + NO_REF_OFFSET;
      default:   alarm = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_write) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_write) begin
      m_tdata <= {cmd.retries, alarm, cmd.delay_ms, cmd.action};
    end
  end

  assign status.op          = op_r;
  assign status.conf_active = conf_r;
  assign status.ack_status  = ack_r;
  assign status.fts_nonzero = first_timestamp != '0;
  assign status.rem_le1     = rem <= 16'd1;
  assign status.div_done    = div_done;
  assign status.out_free    = !m_tvalid || m_tready;

endmodule

>>> src/rars_ctrl.sv
// Controller: pending step, retry count and handshake sequencing.
module rars_ctrl import rars_pkg::*; #(
  parameter int RETRY_LIMIT = RETRY_LIMIT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  rars_status_t status,
  output rars_cmd_t    cmd
);

  `include "report_ack_retry_scheduler_assert.svh"

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_WB   = 4'b1000
  } state_t;

  localparam logic [2:0] STEP_NONE   = 3'd0;
  localparam logic [2:0] STEP_SEND   = 3'd1;
  localparam logic [2:0] STEP_RESEND = 3'd2;
  localparam logic [2:0] STEP_ACK    = 3'd3;
  localparam logic [2:0] STEP_ALARM  = 3'd4;
  localparam logic [2:0] STEP_LOWPWR = 3'd5;

  localparam logic [3:0] ACT_CONF_WAIT = 4'd0;
  localparam logic [3:0] ACT_NOT_DUE   = 4'd1;
  localparam logic [3:0] ACT_DUE       = 4'd2;
  localparam logic [3:0] ACT_SEND      = 4'd3;
  localparam logic [3:0] ACT_RESEND    = 4'd4;
  localparam logic [3:0] ACT_ACK_WAIT  = 4'd5;
  localparam logic [3:0] ACT_ACK_GOT   = 4'd6;
  localparam logic [3:0] ACT_RETRY     = 4'd7;
  localparam logic [3:0] ACT_GIVE_UP   = 4'd8;
  localparam logic [3:0] ACT_ALARM     = 4'd9;
  localparam logic [3:0] ACT_LOWPOWER  = 4'd10;
  localparam logic [3:0] ACT_CLEARED   = 4'd11;

  localparam logic [1:0] ACK_RECEIVED = 2'd1;
  localparam logic [1:0] ACK_TIMEOUT  = 2'd2;

  localparam logic [9:0] DELAY_NONE  = 10'd0;
  localparam logic [9:0] DELAY_SHORT = 10'd500;
  localparam logic [9:0] DELAY_LONG  = 10'd1000;

  localparam logic [1:0] RETRY_MAX = RETRY_LIMIT[1:0];

  state_t     state;
  state_t     state_next;
  logic [2:0] step;
  logic [2:0] step_next;
  logic [1:0] retry;
  logic [1:0] retry_next;
  logic [3:0] action;
  logic [9:0] delay_ms;
  alarm_sel_t alarm_sel;
  logic       need_div;

  always_comb begin
    action     = ACT_CLEARED;
    delay_ms   = DELAY_NONE;
    alarm_sel  = ALM_ZERO;
    step_next  = step;
    retry_next = retry;
    need_div   = 1'b0;
    if (status.op) begin
      step_next = STEP_NONE;
    end else begin
      case (step)
        STEP_SEND: begin
          action    = ACT_SEND;
          delay_ms  = DELAY_LONG;
          step_next = STEP_ACK;
        end
        STEP_RESEND: begin
          action    = ACT_RESEND;
          delay_ms  = DELAY_LONG;
          step_next = STEP_ACK;
        end
        STEP_ACK: begin
          if (status.ack_status == ACK_RECEIVED) begin
            retry_next = '0;
            action     = ACT_ACK_GOT;
            step_next  = STEP_ALARM;
          end else if (status.ack_status == ACK_TIMEOUT) begin
            if (retry < RETRY_MAX) begin
              retry_next = retry + 2'd1;
              action     = ACT_RETRY;
              step_next  = STEP_RESEND;
            end else begin
              retry_next = '0;
              action     = ACT_GIVE_UP;
              step_next  = STEP_ALARM;
            end
          end else begin
            action   = ACT_ACK_WAIT;
            delay_ms = DELAY_LONG;
          end
        end
        STEP_ALARM: begin
          need_div  = status.fts_nonzero;
          alarm_sel = status.fts_nonzero ? ALM_GRID : ALM_NOREF;
          action    = ACT_ALARM;
          step_next = STEP_LOWPWR;
        end
        STEP_LOWPWR: begin
          action    = ACT_LOWPOWER;
          step_next = STEP_NONE;
        end
        default: begin
          step_next = STEP_NONE;
          if (status.conf_active) begin
            action   = ACT_CONF_WAIT;
            delay_ms = DELAY_LONG;
          end else begin
            need_div = 1'b1;
            if (status.rem_le1) begin
              action    = ACT_DUE;
              delay_ms  = DELAY_SHORT;
              step_next = STEP_SEND;
            end else begin
              action    = ACT_NOT_DUE;
              delay_ms  = DELAY_LONG;
              step_next = STEP_ALARM;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_CALC;
      ST_CALC: state_next = need_div ? ST_DIV : ST_WB;
      ST_DIV:  if (status.div_done) state_next = ST_WB;
      ST_WB:   if (status.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign s_tready      = state == ST_IDLE;
  assign cmd.load_in   = s_tvalid && (state == ST_IDLE);
  assign cmd.div_start = (state == ST_CALC) && need_div;
  assign cmd.out_write = (state == ST_WB) && status.out_free;
  assign cmd.action    = action;
  assign cmd.delay_ms  = delay_ms;
  assign cmd.retries   = retry_next;
  assign cmd.alarm_sel = alarm_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_NONE;
      retry <= '0;
    end else begin
      state <= state_next;
      if (cmd.out_write) begin
        step  <= step_next;
        retry <= retry_next;
      end
    end
  end

  `RARS_ASSERT_IMPL(a_write_needs_room, cmd.out_write, status.out_free)
  `RARS_ASSERT_NEXT(a_start_enters_div, cmd.div_start, state == ST_DIV && !status.div_done)
  `RARS_ASSERT_NEXT(a_write_returns_idle, cmd.out_write, state == ST_IDLE)
  `RARS_ASSERT_IMPL(a_step_legal, 1'b1, step <= STEP_LOWPWR && retry <= RETRY_MAX)

endmodule

>>> src/report_ack_retry_scheduler.sv
// Top level of the periodic report scheduler with acknowledge and retry.
// An accepted input is latched; the controller then passes the calc state, the divide state (only
// when the grid check or the aligned alarm runs the serial remainder unit) and the write-back state,
// which writes the output register once it is free. New input is taken only when back in idle.
// Reset clears the pending step, the retry count and the output valid, and loads the
// configuration defaults (normal mode, interval 10, no reference time).
module report_ack_retry_scheduler import rars_pkg::*; #(
  parameter int RETRY_LIMIT  = RETRY_LIMIT_DEF,
  parameter int MIN_INTERVAL = MIN_INTERVAL_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // conf_active, rtc_time[31:0], ack_status[1:0], zero fill
  input  logic [0:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // action[3:0], delay_ms[9:0], alarm_time[31:0], retries_used[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  rars_cmd_t    cmd;
  rars_status_t status;

  rars_ctrl #(
    .RETRY_LIMIT (RETRY_LIMIT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rars_datapath #(
    .MIN_INTERVAL (MIN_INTERVAL)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_op     (s_tuser[0]),
    .in_data   (s_tdata[34:0]),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

>>> verif/report_ack_retry_scheduler_test.sv
// Self-checking testbench for the report scheduler: directed ticks, then random phases.
module report_ack_retry_scheduler_test;
  import rars_pkg::*;

  typedef enum logic [3:0] {
    ACT_CONFIG_WAIT = 4'd0,
    ACT_NOT_DUE     = 4'd1,
    ACT_DUE         = 4'd2,
    ACT_SEND        = 4'd3,
    ACT_RESEND      = 4'd4,
    ACT_ACK_WAIT    = 4'd5,
    ACT_ACK_GOT     = 4'd6,
    ACT_RETRY       = 4'd7,
    ACT_GIVE_UP     = 4'd8,
    ACT_ALARM       = 4'd9,
    ACT_LOW_POWER   = 4'd10,
    ACT_CLEARED     = 4'd11
  } action_t;

  typedef enum logic [2:0] {
    STEP_NONE      = 3'd0,
    STEP_SEND      = 3'd1,
    STEP_RESEND    = 3'd2,
    STEP_ACK_POLL  = 3'd3,
    STEP_SET_ALARM = 3'd4,
    STEP_LOW_POWER = 3'd5
  } step_t;

  typedef enum logic [1:0] {
    ACK_WAITING  = 2'd0,
    ACK_RECEIVED = 2'd1,
    ACK_TIMEOUT  = 2'd2,
    ACK_UNUSED   = 2'd3
  } ack_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  localparam logic [9:0]  DELAY_NONE    = 10'd0;
  localparam logic [9:0]  DELAY_SHORT   = 10'd500;
  localparam logic [9:0]  DELAY_LONG    = 10'd1000;
  localparam logic [31:0] NOREF_OFFSET  = 32'd10;
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          PHASE_TICKS   = 250;
  localparam int          RANDOM_PHASES = 8;

  typedef struct packed {
    op_t         op;
    logic        conf;
    logic [31:0] now;
    ack_t        ack;
  } tick_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [9:0]  delay;
    logic [31:0] alarm;
    logic [1:0]  retries;
  } report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_MODE;
  logic [31:0] cfg_data = '0;

  tick_t   tick_q[$];
  report_t report_q[$];

  logic        mode_q = 1'b0;
  logic [15:0] interval_q = 16'd10;
  logic [31:0] first_ts_q = '0;
  step_t       step_q = STEP_NONE;
  logic [1:0]  retry_q = '0;

  int  failures = 0;
  int  mismatches = 0;
  int  reports_seen = 0;
  int  cycles = 0;
  int  tx_gap = 0;
  int  rx_hold = 0;
  bit  long_hold_done = 1'b0;
  bit  calm = 1'b0;

  report_ack_retry_scheduler u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] grid_period(input logic mode, input logic [15:0] interval);
    if (mode == 1'b0 || interval < MIN_INTERVAL_DEF) return MIN_INTERVAL_DEF;
    return {16'd0, interval};
  endfunction

  function automatic report_t next_report(input tick_t t);
    report_t     r;
    logic [31:0] e;
    logic [31:0] d;
    logic [63:0] k;
    e = grid_period(mode_q, interval_q);
    r.action = ACT_CLEARED;
    r.delay = DELAY_NONE;
    r.alarm = '0;
    if (t.op == OP_CLEAR) begin
      step_q = STEP_NONE;
    end else begin
      case (step_q)
        STEP_SEND, STEP_RESEND: begin
          r.action = (step_q == STEP_SEND) ? ACT_SEND : ACT_RESEND;
          r.delay = DELAY_LONG;
          step_q = STEP_ACK_POLL;
        end
        STEP_ACK_POLL: begin
          if (t.ack == ACK_RECEIVED) begin
            retry_q = '0;
            r.action = ACT_ACK_GOT;
            step_q = STEP_SET_ALARM;
          end else if (t.ack == ACK_TIMEOUT) begin
            if (retry_q < RETRY_LIMIT_DEF) begin
              retry_q = retry_q + 2'd1;
              r.action = ACT_RETRY;
              step_q = STEP_RESEND;
            end else begin
              retry_q = '0;
              r.action = ACT_GIVE_UP;
              step_q = STEP_SET_ALARM;
            end
          end else begin
            r.action = ACT_ACK_WAIT;
            r.delay = DELAY_LONG;
          end
        end
        STEP_SET_ALARM: begin
          if (first_ts_q != 0) begin
            d = t.now - first_ts_q;
            k = {32'd0, d / e} + 64'd1;
            r.alarm = 32'(k * {32'd0, e} + {32'd0, first_ts_q});
          end else begin
            r.alarm = t.now + NOREF_OFFSET;
          end
          r.action = ACT_ALARM;
          step_q = STEP_LOW_POWER;
        end
        STEP_LOW_POWER: begin
          r.action = ACT_LOW_POWER;
          step_q = STEP_NONE;
        end
        default: begin
          step_q = STEP_NONE;
          if (t.conf) begin
            r.action = ACT_CONFIG_WAIT;
            r.delay = DELAY_LONG;
          end else if (((t.now - first_ts_q) % e) <= 1) begin
            r.action = ACT_DUE;
            r.delay = DELAY_SHORT;
            step_q = STEP_SEND;
          end else begin
            r.action = ACT_NOT_DUE;
            r.delay = DELAY_LONG;
            step_q = STEP_SET_ALARM;
          end
        end
      endcase
    end
    r.retries = retry_q;
    return r;
  endfunction

  task automatic push_tick(input op_t op, input logic conf, input logic [31:0] now,
                           input ack_t ack);
    tick_t t;
    t.op = op;
    t.conf = conf;
    t.now = now;
    t.ack = ack;
    tick_q.push_back(t);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (tick_q.size() != 0 || s_tvalid || report_q.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic push_random_phase(input logic [31:0] e, input logic [31:0] fts);
    int          sel;
    logic [31:0] d;
    logic [31:0] now;
    ack_t        ack;
    op_t         op;
    for (int i = 0; i < PHASE_TICKS; i++) begin
      sel = $urandom_range(0, 9);
      d = e * $urandom_range(0, 32'hFFFF_FFFF / e - 1);
      if (sel < 5) now = fts + d + $urandom_range(0, 1);
      else if (sel == 5) now = fts + d + (($urandom_range(0, 1) != 0) ? e - 1 : 32'd2);
      else now = $urandom();
      sel = $urandom_range(0, 9);
      if (sel < 2) ack = ACK_WAITING;
      else if (sel < 4) ack = ACK_RECEIVED;
      else if (sel < 9) ack = ACK_TIMEOUT;
      else ack = ACK_UNUSED;
      op = ($urandom_range(0, 24) == 0) ? OP_CLEAR : OP_TICK;
      push_tick(op, $urandom_range(0, 9) == 0, now, ack);
    end
  endtask

  initial begin
    logic        mode;
    logic [15:0] interval;
    logic [31:0] fts;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Default settings: interval 10, no reference time.
    push_tick(OP_CLEAR, 1'b0, 32'd0, ACK_WAITING);
    push_tick(OP_TICK, 1'b1, 32'd0, ACK_WAITING);
    push_tick(OP_TICK, 1'b0, 32'd5, ACK_RECEIVED);
    push_tick(OP_TICK, 1'b0, 32'hFFFF_FFFF, ACK_TIMEOUT);
    push_tick(OP_TICK, 1'b0, 32'd7, ACK_WAITING);
    push_tick(OP_TICK, 1'b0, 32'd21, ACK_WAITING);
    push_tick(OP_TICK, 1'b1, 32'd22, ACK_WAITING);
    push_tick(OP_TICK, 1'b0, 32'd23, ACK_WAITING);
    push_tick(OP_TICK, 1'b0, 32'd24, ACK_UNUSED);
    push_tick(OP_TICK, 1'b0, 32'd25, ACK_TIMEOUT);
    push_tick(OP_TICK, 1'b0, 32'd26, ACK_WAITING);
    push_tick(OP_TICK, 1'b0, 32'd27, ACK_TIMEOUT);
    push_tick(OP_TICK, 1'b0, 32'd28, ACK_WAITING);
    push_tick(OP_TICK, 1'b0, 32'd29, ACK_TIMEOUT);
    push_tick(OP_TICK, 1'b0, 32'hFFFF_FFF8, ACK_WAITING);
    push_tick(OP_TICK, 1'b0, 32'd31, ACK_WAITING);
    push_tick(OP_TICK, 1'b0, 32'd30, ACK_WAITING);
    push_tick(OP_TICK, 1'b0, 32'd31, ACK_WAITING);
    push_tick(OP_TICK, 1'b0, 32'd32, ACK_RECEIVED);
    push_tick(OP_TICK, 1'b0, 32'd40, ACK_WAITING);
    push_tick(OP_TICK, 1'b0, 32'd41, ACK_WAITING);
    push_tick(OP_TICK, 1'b0, 32'd42, ACK_WAITING);
    push_tick(OP_TICK, 1'b0, 32'd43, ACK_TIMEOUT);
    push_tick(OP_CLEAR, 1'b0, 32'd44, ACK_TIMEOUT);
    push_tick(OP_TICK, 1'b0, 32'd52, ACK_WAITING);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      mode = 1'b1;
      fts = $urandom();
      case (p)
        0: begin interval = 16'hFFFF; fts = 32'hFFFF_FFFF; end
        1: interval = 16'd0;
        2: begin mode = 1'b0; interval = 16'hFFFF; fts = 32'd0; end
        3: interval = 16'd9;
        4: interval = 16'd11;
        5: interval = $urandom_range(10, 300);
        6: interval = $urandom();
        default: interval = $urandom_range(10, 60);
      endcase
      write_reg(CFG_MODE, {31'd0, mode});
      write_reg(CFG_INTERVAL, {16'd0, interval});
      write_reg(CFG_FIRST_TS, fts);
      if (p == RANDOM_PHASES - 1) calm = 1'b1;
      push_random_phase(grid_period(mode, interval), fts);
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (failures == 0 && report_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin : driver
    tick_t t;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap <= 0;
    end else if (s_tvalid && !s_tready) begin
    end else if (tx_gap != 0) begin
      s_tvalid <= 1'b0;
      tx_gap <= tx_gap - 1;
    end else if (tick_q.size() != 0) begin
      t = tick_q.pop_front();
      s_tdata <= {5'd0, t.ack, t.now, t.conf};
      s_tuser <= t.op;
      s_tvalid <= 1'b1;
      if (!calm && $urandom_range(0, 6) == 0) tx_gap <= $urandom_range(1, 4);
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  always @(posedge clk) begin : sink
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold != 0) begin
      m_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (!long_hold_done && reports_seen >= 700) begin
      long_hold_done <= 1'b1;
      m_tready <= 1'b0;
      rx_hold <= 300;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      rx_hold <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    tick_t   t;
    report_t got;
    report_t exp_r;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE:     mode_q = cfg_data[0];
          CFG_INTERVAL: interval_q = cfg_data[15:0];
          CFG_FIRST_TS: first_ts_q = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        t.op = op_t'(s_tuser[0]);
        t.conf = s_tdata[0];
        t.now = s_tdata[32:1];
        t.ack = ack_t'(s_tdata[34:33]);
        report_q.push_back(next_report(t));
      end
      if (m_tvalid && m_tready) begin
        reports_seen++;
        got.action = m_tdata[3:0];
        got.delay = m_tdata[13:4];
        got.alarm = m_tdata[45:14];
        got.retries = m_tdata[47:46];
        if (report_q.size() == 0) begin
          failures++;
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: action %0d delay %0d alarm %h retries %0d",
                     got.action, got.delay, got.alarm, got.retries);
        end else begin
          exp_r = report_q.pop_front();
          if (got.action !== exp_r.action || got.delay !== exp_r.delay ||
              got.alarm !== exp_r.alarm || got.retries !== exp_r.retries) begin
            failures++;
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected action %0d delay %0d alarm %h retries %0d, got action %0d delay %0d alarm %h retries %0d",
                       exp_r.action, exp_r.delay, exp_r.alarm, exp_r.retries,
                       got.action, got.delay, got.alarm, got.retries);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

>>> filelist.f
+incdir+src
src/rars_pkg.sv
src/rars_mod_unit.sv
src/rars_datapath.sv
src/rars_ctrl.sv
src/report_ack_retry_scheduler.sv
verif/report_ack_retry_scheduler_test.sv
